/* rtl/bkvt_pkg.sv */
// ----------------------------------------------------------------------------
// bkvt_pkg
// Shared types, codes and constants of the binary key-value tokenizer.
// ----------------------------------------------------------------------------
package bkvt_pkg;

    // default depth limit of nested objects
    localparam int MAX_DEPTH_DEF = 15;
    // hardware level counter saturates here
    localparam int LEVEL_HW_MAX = 15;

    // element type bytes
    localparam logic [7:0] TYPE_OBJECT = 8'h00;
    localparam logic [7:0] TYPE_STRING = 8'h01;
    localparam logic [7:0] TYPE_INT    = 8'h02;
    localparam logic [7:0] TYPE_CLOSE  = 8'h08;
    localparam logic [7:0] BYTE_NUL    = 8'h00;

    // from this level on any type byte is taken as a bare key
    localparam logic [3:0] LEVEL_ANY_TYPE = 4'd4;
    localparam logic [3:0] ROOT_KEY_LEN   = 4'd9;

    typedef enum logic [3:0] {
        PH_ROOT_TYPE = 4'd0,
        PH_ROOT_KEY  = 4'd1,
        PH_TYPE      = 4'd2,
        PH_KEY       = 4'd3,
        PH_STR       = 4'd4,
        PH_INT       = 4'd5,
        PH_IDLE      = 4'd6
    } phase_t;

    typedef enum logic [1:0] {
        PV_NONE   = 2'd0,
        PV_STRING = 2'd1,
        PV_INT    = 2'd2
    } pend_t;

    typedef enum logic [3:0] {
        EV_NONE     = 4'd0,
        EV_KEY_BYTE = 4'd1,
        EV_KEY_END  = 4'd2,
        EV_STR_BYTE = 4'd3,
        EV_STR_END  = 4'd4,
        EV_INT_DONE = 4'd5,
        EV_OPEN     = 4'd6,
        EV_CLOSE    = 4'd7,
        EV_DONE     = 4'd8,
        EV_ERROR    = 4'd9,
        EV_IDLE     = 4'd10
    } event_t;

    // parser state carried from byte to byte
    typedef struct packed {
        phase_t      phase;
        logic [3:0]  level;
        logic [1:0]  int_cnt;
        logic [23:0] int_partial;
        logic [3:0]  root_pos;
        pend_t       pend;
        logic        done;
        logic        err;
    } state_t;

    // one token event
    typedef struct packed {
        event_t             kind;
        logic [7:0]         byte_value;
        logic signed [31:0] int_value;
        logic [3:0]         nest_depth;
        logic               finished;
    } result_t;

    localparam state_t STATE_RESET = '{
        phase:       PH_ROOT_TYPE,
        level:       4'd0,
        int_cnt:     2'd0,
        int_partial: 24'd0,
        root_pos:    4'd0,
        pend:        PV_NONE,
        done:        1'b0,
        err:         1'b0
    };

    // expected root key, one character per position
    function automatic logic [7:0] root_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h73; // s
            4'd1:    c = 8'h68; // h
            4'd2:    c = 8'h6f; // o
            4'd3:    c = 8'h72; // r
            4'd4:    c = 8'h74; // t
            4'd5:    c = 8'h63; // c
            4'd6:    c = 8'h75; // u
            4'd7:    c = 8'h74; // t
            4'd8:    c = 8'h73; // s
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* rtl/bkvt_step.sv */
// ----------------------------------------------------------------------------
// bkvt_step
// Single-byte parser step: next state and token event from current state.
// ----------------------------------------------------------------------------
module bkvt_step #(
    parameter int MAX_DEPTH = bkvt_pkg::MAX_DEPTH_DEF
) (
    input  bkvt_pkg::state_t  cur,
    input  logic [7:0]        in_byte,
    input  logic              last_byte,
    output bkvt_pkg::state_t  nxt,
    output bkvt_pkg::result_t res
);

    localparam logic [3:0] DEPTH_CAP = (MAX_DEPTH < bkvt_pkg::LEVEL_HW_MAX)
                                       ? 4'(MAX_DEPTH) : 4'(bkvt_pkg::LEVEL_HW_MAX);

    bkvt_pkg::event_t   kind;
    logic [7:0]         bv;
    logic [31:0]        iv;
    logic               fail;
    logic               open_req;
    bkvt_pkg::state_t   st;

    // parse one byte
    always_comb begin
        st       = cur;
        kind     = bkvt_pkg::EV_NONE;
        bv       = 8'd0;
        iv       = 32'd0;
        fail     = 1'b0;
        open_req = 1'b0;

        case (cur.phase)
            bkvt_pkg::PH_ROOT_TYPE: begin
                if (in_byte == bkvt_pkg::TYPE_OBJECT) begin
                    st.level    = 4'd1;
                    kind        = bkvt_pkg::EV_OPEN;
                    st.root_pos = 4'd0;
                    st.phase    = bkvt_pkg::PH_ROOT_KEY;
                end else begin
                    fail = 1'b1;
                end
            end
            bkvt_pkg::PH_ROOT_KEY: begin
                if (cur.root_pos < bkvt_pkg::ROOT_KEY_LEN) begin
                    if (in_byte == bkvt_pkg::root_char(cur.root_pos)) begin
                        kind        = bkvt_pkg::EV_KEY_BYTE;
                        bv          = in_byte;
                        st.root_pos = cur.root_pos + 4'd1;
                    end else begin
                        fail = 1'b1;
                    end
                end else if (in_byte == bkvt_pkg::BYTE_NUL) begin
                    kind     = bkvt_pkg::EV_KEY_END;
                    st.phase = bkvt_pkg::PH_TYPE;
                end else begin
                    fail = 1'b1;
                end
            end
            bkvt_pkg::PH_TYPE: begin
                if (in_byte == bkvt_pkg::TYPE_CLOSE) begin
                    if (cur.level <= 4'd1) begin
                        st.level = 4'd0;
                        kind     = bkvt_pkg::EV_DONE;
                        st.done  = 1'b1;
                        st.phase = bkvt_pkg::PH_IDLE;
                    end else begin
                        st.level = cur.level - 4'd1;
                        kind     = bkvt_pkg::EV_CLOSE;
                    end
                end else if (cur.level <= 4'd1) begin
                    if (in_byte == bkvt_pkg::TYPE_OBJECT) begin
                        open_req = 1'b1;
                    end else begin
                        fail = 1'b1;
                    end
                end else if (in_byte == bkvt_pkg::TYPE_OBJECT) begin
                    open_req = 1'b1;
                end else if (in_byte == bkvt_pkg::TYPE_STRING) begin
                    st.pend  = bkvt_pkg::PV_STRING;
                    st.phase = bkvt_pkg::PH_KEY;
                end else if (in_byte == bkvt_pkg::TYPE_INT) begin
                    st.pend  = bkvt_pkg::PV_INT;
                    st.phase = bkvt_pkg::PH_KEY;
                end else if (cur.level >= bkvt_pkg::LEVEL_ANY_TYPE) begin
                    st.pend  = bkvt_pkg::PV_NONE;
                    st.phase = bkvt_pkg::PH_KEY;
                end else begin
                    fail = 1'b1;
                end
                // object open with depth saturation
                if (open_req) begin
                    if (cur.level >= DEPTH_CAP) begin
                        st.level = DEPTH_CAP;
                        fail     = 1'b1;
                    end else begin
                        st.level = cur.level + 4'd1;
                        kind     = bkvt_pkg::EV_OPEN;
                        st.pend  = bkvt_pkg::PV_NONE;
                        st.phase = bkvt_pkg::PH_KEY;
                    end
                end
            end
            bkvt_pkg::PH_KEY: begin
                if (in_byte != bkvt_pkg::BYTE_NUL) begin
                    kind = bkvt_pkg::EV_KEY_BYTE;
                    bv   = in_byte;
                end else begin
                    kind           = bkvt_pkg::EV_KEY_END;
                    st.int_cnt     = 2'd0;
                    st.int_partial = 24'd0;
                    case (cur.pend)
                        bkvt_pkg::PV_STRING: st.phase = bkvt_pkg::PH_STR;
                        bkvt_pkg::PV_INT:    st.phase = bkvt_pkg::PH_INT;
                        default:             st.phase = bkvt_pkg::PH_TYPE;
                    endcase
                    st.pend = bkvt_pkg::PV_NONE;
                end
            end
            bkvt_pkg::PH_STR: begin
                if (in_byte != bkvt_pkg::BYTE_NUL) begin
                    kind = bkvt_pkg::EV_STR_BYTE;
                    bv   = in_byte;
                end else begin
                    kind     = bkvt_pkg::EV_STR_END;
                    st.phase = bkvt_pkg::PH_TYPE;
                end
            end
            bkvt_pkg::PH_INT: begin
                // little-endian assembly, top byte completes the value
                case (cur.int_cnt)
                    2'd0: begin
                        st.int_partial[7:0] = in_byte;
                        st.int_cnt          = 2'd1;
                    end
                    2'd1: begin
                        st.int_partial[15:8] = in_byte;
                        st.int_cnt           = 2'd2;
                    end
                    2'd2: begin
                        st.int_partial[23:16] = in_byte;
                        st.int_cnt            = 2'd3;
                    end
                    default: begin
                        kind           = bkvt_pkg::EV_INT_DONE;
                        iv             = {in_byte, cur.int_partial};
                        st.int_cnt     = 2'd0;
                        st.int_partial = 24'd0;
                        st.phase       = bkvt_pkg::PH_TYPE;
                    end
                endcase
            end
            default: begin
                kind = bkvt_pkg::EV_IDLE;
            end
        endcase

        // any failure parks the parser until end of file
        if (fail) begin
            st.err   = 1'b1;
            kind     = bkvt_pkg::EV_ERROR;
            bv       = 8'd0;
            iv       = 32'd0;
            st.phase = bkvt_pkg::PH_IDLE;
        end

        res.nest_depth = st.level;
        res.finished   = 1'b0;

        // final byte: verdict on the whole file, then restart
        if (last_byte) begin
            if (st.err) begin
                kind = bkvt_pkg::EV_ERROR;
            end else if (st.done || (st.phase == bkvt_pkg::PH_TYPE && st.level == 4'd1)) begin
                kind = bkvt_pkg::EV_DONE;
            end else begin
                kind = bkvt_pkg::EV_ERROR;
            end
            bv           = 8'd0;
            iv           = 32'd0;
            res.finished = 1'b1;
            st           = bkvt_pkg::STATE_RESET;
        end

        res.kind       = kind;
        res.byte_value = bv;
        res.int_value  = iv;
        nxt            = st;
    end

endmodule

/* rtl/binary_keyvalue_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// binary_keyvalue_tokenizer_core
// Streaming tokenizer for binary key-value files, one event per input byte.
// ----------------------------------------------------------------------------
// Takes one file byte per transaction and returns exactly one token event per
// byte, in order. Throughput is one byte per clock cycle while results are
// taken: the parser state is updated by a single combinational step between
// the input register and the result register, so a byte may follow in every
// cycle. Each byte is held in the input register and its result then in the
// result register. While a result waits on m_tready the input register takes
// one more byte, and s_tready then follows m_tready until the result is taken.
// A byte with s_tlast set ends the file: its result carries m_tlast with the
// file verdict, and the next byte starts a new file.
module binary_keyvalue_tokenizer_core #(
    parameter int MAX_DEPTH = bkvt_pkg::MAX_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input transaction
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // last_byte
    // result transaction
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [3:0] event_kind, [11:4] byte_value,
                                   // [43:12] int_value, [47:44] nest_depth
    output logic        m_tlast    // finished
);

    localparam logic [3:0] DEPTH_CAP = (MAX_DEPTH < bkvt_pkg::LEVEL_HW_MAX)
                                       ? 4'(MAX_DEPTH) : 4'(bkvt_pkg::LEVEL_HW_MAX);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_last_reg;
    logic               adv;
    bkvt_pkg::state_t   state_reg;
    bkvt_pkg::state_t   state_next;
    bkvt_pkg::result_t  res_next;
    bkvt_pkg::result_t  res_reg;
    logic               m_valid_reg;

    // pipeline advance when the result slot is free or being emptied
    assign adv      = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // parser step
    bkvt_step #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_step (
        .cur       (state_reg),
        .in_byte   (in_byte_reg),
        .last_byte (in_last_reg),
        .nxt       (state_next),
        .res       (res_next)
    );

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bkvt_pkg::STATE_RESET;
        end else if (adv) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {res_reg.nest_depth, res_reg.int_value, res_reg.byte_value,
                       res_reg.kind};
    assign m_tlast  = res_reg.finished;

    // end of file always returns the parser to its reset state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && in_last_reg) |=>
            (state_reg.phase == bkvt_pkg::PH_ROOT_TYPE && state_reg.level == 4'd0))
        else $error("parser state not cleared after final byte");

    // level never passes the depth cap
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.level <= DEPTH_CAP)
        else $error("nesting level above depth cap");

    // a recorded error parks the parser
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.err |-> state_reg.phase == bkvt_pkg::PH_IDLE)
        else $error("error flag set outside idle phase");

    // file verdict is done or error
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.finished) |->
            (res_reg.kind == bkvt_pkg::EV_DONE || res_reg.kind == bkvt_pkg::EV_ERROR))
        else $error("final result without a verdict");

    // byte payload only on key and string byte events
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.kind != bkvt_pkg::EV_KEY_BYTE
                     && res_reg.kind != bkvt_pkg::EV_STR_BYTE) |->
            res_reg.byte_value == 8'd0)
        else $error("byte value on a non-byte event");

endmodule
